@@ rtl/core/grid_ray_caster_dda_defines.svh @@
// Assertion macros for the grid ray caster checker.
// Used by grc_checker.sv only; relies on clk and rst in the including scope.
`ifndef GRID_RAY_CASTER_DDA_DEFINES_SVH
`define GRID_RAY_CASTER_DDA_DEFINES_SVH

// same-cycle implication
`define GRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/grc_pkg.sv @@
// Shared constants, codes and divider interface types for the grid ray caster.
// No dependencies.
`timescale 1ns / 1ps
package grc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAP_SIZE  = 64;
  localparam int MAP_W     = $clog2(MAP_SIZE);
  localparam int ADDR_W    = 2 * MAP_W;
  localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
  localparam int CELL_W    = MAP_W + 2;
  localparam int POS_W     = MAP_W + FRAC_BITS;
  localparam int MAX_STEPS = 128;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam int DIR_W      = 19;
  localparam int PM_W       = 18;
  localparam int SCR_W      = 13;
  localparam int COL_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam int DIV_NW    = 2 * FRAC_BITS + 1;
  localparam int DIV_DW    = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NW);

  localparam logic [1:0] STATUS_HIT   = 2'd0;
  localparam logic [1:0] STATUS_LIMIT = 2'd1;
  localparam logic [1:0] STATUS_WRITE = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_W  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_H  = 3'd6;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/core/grid_ray_caster_dda.sv @@
// Grid ray caster top level: config registers, sequencer, shared multiplier, DDA walk.
// Depends on grc_pkg, grc_div, grc_ram.
//
//  channel  signals                         role
//  cfg      cfg_we cfg_index cfg_data       register write, no wait
//  in       in_valid in_ready + fields      map write or cast request
//  out      out_valid out_ready + fields    one result per request
//
// A cast runs four divisions (column scale, two step sizes, line height) in the shared
// divider, and each DDA step passes through ST_WALK and ST_CHECK for the map read.
// After reset a clearing pass empties every map cell; in_ready stays low meanwhile.
// One request at a time; a finished result waits in the output register for out_ready.
`timescale 1ns / 1ps
module grid_ray_caster_dda (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [grc_pkg::MAP_W-1:0]          cell_x,
  input  logic [grc_pkg::MAP_W-1:0]          cell_y,
  input  logic                               cell_wall,
  input  logic [grc_pkg::COL_W-1:0]          column,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [31:0]                        distance,
  output logic                               wall_side,
  output logic [grc_pkg::MAP_W-1:0]          hit_x,
  output logic [grc_pkg::MAP_W-1:0]          hit_y,
  output logic [grc_pkg::POS_W-1:0]          intersect_x,
  output logic [grc_pkg::POS_W-1:0]          intersect_y,
  output logic [15:0]                        strip_height
);
  import grc_pkg::*;

  typedef enum logic [16:0] {
    ST_CLR   = 17'd1 << 0,
    ST_IDLE  = 17'd1 << 1,
    ST_SCALE = 17'd1 << 2,
    ST_R1    = 17'd1 << 3,
    ST_R2    = 17'd1 << 4,
    ST_R3    = 17'd1 << 5,
    ST_D0    = 17'd1 << 6,
    ST_D1    = 17'd1 << 7,
    ST_S1    = 17'd1 << 8,
    ST_S2    = 17'd1 << 9,
    ST_WALK  = 17'd1 << 10,
    ST_CHECK = 17'd1 << 11,
    ST_I1    = 17'd1 << 12,
    ST_I2    = 17'd1 << 13,
    ST_L0    = 17'd1 << 14,
    ST_L1    = 17'd1 << 15,
    ST_OUT   = 17'd1 << 16
  } state_t;

  localparam logic signed [51:0] RAY_LIM = 52'sh7FFF_FFFF;
  localparam logic signed [49:0] POS_HI  = 50'sd2 ** POS_W - 50'sd1;
  localparam logic signed [CELL_W-1:0] CELL_HI = CELL_W'(MAP_SIZE);

  // configuration
  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [DIR_W-1:0] dir_x, dir_y;
  logic [PM_W-1:0]         plane_mag;
  logic [SCR_W-1:0]        scr_w, scr_h;

  // working registers
  state_t                   state;
  logic                     ax;
  logic                     is_wr;
  logic [ADDR_W-1:0]        clr_cnt;
  logic signed [31:0]       scale;
  logic signed [31:0]       rx, ry;
  logic [31:0]              dx, dy, sx, sy, ray_dist;
  logic signed [CELL_W-1:0] cx, cy;
  logic [STEP_W-1:0]        nsteps;
  logic                     side;
  logic [1:0]               res_st;
  logic [POS_W-1:0]         ix, iy;
  logic [15:0]              lh;
  logic signed [65:0]       prod;

  // combinational helpers
  logic signed [32:0]       mul_a, mul_b;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic                     ram_wdata, ram_rdata;
  logic signed [31:0]       r_ax;
  logic [31:0]              mag_ax, delta_ax;
  logic [POS_W-1:0]         pos_ax;
  logic [16:0]              part;
  logic signed [51:0]       rsum;
  logic signed [31:0]       rsat;
  logic [47:0]              side_v;
  logic signed [49:0]       ipos;
  logic [POS_W-1:0]         iclamp;
  logic                     x_take;
  logic signed [CELL_W-1:0] cx_n, cy_n;
  logic [32:0]              sx_add, sy_add;
  logic                     oob, hit;
  logic [SCR_W-1:0]         sw_eff;

  assign in_ready = (state == ST_IDLE);

  assign r_ax     = ax ? ry : rx;
  assign mag_ax   = r_ax[31] ? 32'(-r_ax) : 32'(r_ax);
  assign delta_ax = ax ? dy : dx;
  assign pos_ax   = ax ? pos_y : pos_x;
  assign part     = r_ax[31] ? {1'b0, pos_ax[FRAC_BITS-1:0]}
                             : 17'h1_0000 - {1'b0, pos_ax[FRAC_BITS-1:0]};
  assign sw_eff   = (scr_w == '0) ? SCR_W'(1) : scr_w;

  // ray component: dir + floor(t * scale), saturated
  assign rsum = (ax ? 52'(dir_y) : 52'(dir_x)) + 52'(prod >>> FRAC_BITS);
  always_comb begin
    if (rsum > RAY_LIM) begin
      rsat = 32'(RAY_LIM);
    end else if (rsum < -RAY_LIM) begin
      rsat = 32'(-RAY_LIM);
    end else begin
      rsat = 32'(rsum);
    end
  end

  assign side_v = prod[63:FRAC_BITS];
  assign ipos   = r_ax[31] ? 50'(pos_ax) - 50'(side_v) : 50'(pos_ax) + 50'(side_v);
  always_comb begin
    if (ipos < 50'sd0) begin
      iclamp = '0;
    end else if (ipos > POS_HI) begin
      iclamp = POS_HI[POS_W-1:0];
    end else begin
      iclamp = ipos[POS_W-1:0];
    end
  end

  // DDA step
  assign x_take = sx < sy;
  assign cx_n   = x_take ? (rx[31] ? cx - 1'b1 : cx + 1'b1) : cx;
  assign cy_n   = x_take ? cy : (ry[31] ? cy - 1'b1 : cy + 1'b1);
  assign sx_add = {1'b0, sx} + {1'b0, dx};
  assign sy_add = {1'b0, sy} + {1'b0, dy};
  assign oob    = (cx < 0) || (cy < 0) || (cx >= CELL_HI) || (cy >= CELL_HI);
  assign hit    = oob || ram_rdata;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_R1: begin
        mul_a = ax ? 33'(dir_x) : -33'(dir_y);
        mul_b = 33'({1'b0, plane_mag});
      end
      ST_R2: begin
        mul_a = 33'(prod >>> FRAC_BITS);
        mul_b = 33'(scale);
      end
      ST_S1: begin
        mul_a = 33'({1'b0, part});
        mul_b = {1'b0, delta_ax};
      end
      ST_I1: begin
        mul_a = {1'b0, mag_ax};
        mul_b = {1'b0, ray_dist};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state)
      ST_IDLE: begin
        div_req.start = in_valid && (op == OP_CAST);
        div_req.num   = DIV_NW'({column, 1'b0}) << FRAC_BITS;
        div_req.den   = DIV_DW'(sw_eff);
      end
      ST_D0: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(1) << (2 * FRAC_BITS);
        div_req.den   = mag_ax;
      end
      ST_L0: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(scr_h) << FRAC_BITS;
        div_req.den   = ray_dist;
      end
      default: div_req = '0;
    endcase
  end

  // map port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = 1'b0;
    if (state == ST_CLR) begin
      ram_we = 1'b1;
    end else if (state == ST_IDLE && in_valid && op == OP_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = {cell_y, cell_x};
      ram_wdata = cell_wall;
    end
  end
  assign ram_raddr = {cy_n[MAP_W-1:0], cx_n[MAP_W-1:0]};

  grc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  grc_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    prod <= 66'(mul_a) * 66'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      dir_x     <= 19'sd65536;
      dir_y     <= '0;
      plane_mag <= 18'd42553;
      scr_w     <= 13'd640;
      scr_h     <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_X: pos_x     <= cfg_data[POS_W-1:0];
        CFG_POS_Y: pos_y     <= cfg_data[POS_W-1:0];
        CFG_DIR_X: dir_x     <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y: dir_y     <= cfg_data[DIR_W-1:0];
        CFG_PLANE: plane_mag <= cfg_data[PM_W-1:0];
        CFG_SCR_W: scr_w     <= cfg_data[SCR_W-1:0];
        CFG_SCR_H: scr_h     <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      ax        <= 1'b0;
    end else begin
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(MAP_CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            is_wr <= (op == OP_WRITE);
            state <= (op == OP_CAST) ? ST_SCALE : ST_OUT;
          end
        end
        ST_SCALE: begin
          if (div_rsp.done) begin
            scale <= $signed(div_rsp.quo[31:0]) - (32'sd1 <<< FRAC_BITS);
            ax    <= 1'b0;
            state <= ST_R1;
          end
        end
        ST_R1: state <= ST_R2;
        ST_R2: state <= ST_R3;
        ST_R3: begin
          if (ax) begin
            ry    <= rsat;
            ax    <= 1'b0;
            state <= ST_D0;
          end else begin
            rx    <= rsat;
            ax    <= 1'b1;
            state <= ST_R1;
          end
        end
        ST_D0: state <= ST_D1;
        ST_D1: begin
          if (div_rsp.done) begin
            if (ax) begin
              dy    <= div_rsp.quo[DIV_NW-1] ? '1 : div_rsp.quo[31:0];
              ax    <= 1'b0;
              state <= ST_S1;
            end else begin
              dx    <= div_rsp.quo[DIV_NW-1] ? '1 : div_rsp.quo[31:0];
              ax    <= 1'b1;
              state <= ST_D0;
            end
          end
        end
        ST_S1: state <= ST_S2;
        ST_S2: begin
          if (ax) begin
            sy       <= (side_v[47:32] != '0) ? '1 : side_v[31:0];
            ax       <= 1'b0;
            cx       <= CELL_W'(pos_x[POS_W-1:FRAC_BITS]);
            cy       <= CELL_W'(pos_y[POS_W-1:FRAC_BITS]);
            nsteps   <= '0;
            ray_dist <= '0;
            side     <= 1'b0;
            state    <= ST_WALK;
          end else begin
            sx    <= (side_v[47:32] != '0) ? '1 : side_v[31:0];
            ax    <= 1'b1;
            state <= ST_S1;
          end
        end
        ST_WALK: begin
          cx     <= cx_n;
          cy     <= cy_n;
          nsteps <= nsteps + 1'b1;
          if (x_take) begin
            ray_dist <= sx;
            sx       <= sx_add[32] ? '1 : sx_add[31:0];
            side     <= 1'b0;
          end else begin
            ray_dist <= sy;
            sy       <= sy_add[32] ? '1 : sy_add[31:0];
            side     <= 1'b1;
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (hit) begin
            res_st <= STATUS_HIT;
            ax     <= 1'b0;
            state  <= ST_I1;
          end else if (nsteps == STEP_W'(MAX_STEPS)) begin
            res_st <= STATUS_LIMIT;
            ax     <= 1'b0;
            state  <= ST_I1;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_I1: state <= ST_I2;
        ST_I2: begin
          if (ax) begin
            iy    <= iclamp;
            ax    <= 1'b0;
            state <= ST_L0;
          end else begin
            ix    <= iclamp;
            ax    <= 1'b1;
            state <= ST_I1;
          end
        end
        ST_L0: state <= ST_L1;
        ST_L1: begin
          if (div_rsp.done) begin
            lh    <= (div_rsp.quo[DIV_NW-1:16] != '0) ? '1 : div_rsp.quo[15:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      if (is_wr) begin
        status       <= STATUS_WRITE;
        distance     <= '0;
        wall_side    <= 1'b0;
        hit_x        <= '0;
        hit_y        <= '0;
        intersect_x  <= '0;
        intersect_y  <= '0;
        strip_height <= '0;
      end else begin
        status       <= res_st;
        distance     <= ray_dist;
        wall_side    <= side;
        hit_x        <= (cx < 0) ? '0 : (cx >= CELL_HI) ? MAP_W'(MAP_SIZE - 1)
                                                        : cx[MAP_W-1:0];
        hit_y        <= (cy < 0) ? '0 : (cy >= CELL_HI) ? MAP_W'(MAP_SIZE - 1)
                                                        : cy[MAP_W-1:0];
        intersect_x  <= ix;
        intersect_y  <= iy;
        strip_height <= lh;
      end
    end
  end

endmodule

@@ rtl/core/grc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/grc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on grc_pkg (widths, div_req_t, div_rsp_t).
`timescale 1ns / 1ps
module grc_div (
  input  logic              clk,
  input  logic              rst,
  input  grc_pkg::div_req_t req,
  output grc_pkg::div_rsp_t rsp
);
  import grc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DW-1:0]    rem;
  logic [DIV_NW-1:0]    quo;
  logic [DIV_DW-1:0]    den;
  logic [DIV_DW:0]      shl;
  logic [DIV_DW:0]      dif;
  logic                 ge;

  assign shl = {rem, quo[DIV_NW-1]};
  assign ge  = shl >= {1'b0, den};
  assign dif = shl - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= ge ? dif[DIV_DW-1:0] : shl[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ rtl/core/grc_checker.sv @@
// Port-level checker for the grid ray caster, bound to the top level.
// Depends on grc_pkg and grid_ray_caster_dda_defines.svh.
`timescale 1ns / 1ps
`include "grid_ray_caster_dda_defines.svh"
module grc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] distance,
  input logic [15:0] strip_height
);
  import grc_pkg::*;

  `GRC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance), "result dropped while stalled")
  `GRC_ASSERT_IMP(a_clear_busy, $fell(rst), !in_ready, "request taken during map clear")
  `GRC_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while busy")
  `GRC_ASSERT_IMP(a_write_zero, out_valid && status == STATUS_WRITE, distance == '0 && strip_height == '0, "map write result not zero")

endmodule

bind grid_ray_caster_dda grc_checker u_grc_checker (.*);

@@ tb/tb_top.sv @@
// Testbench for grid_ray_caster_dda: map writes and column casts checked against a
// fixed-point DDA predictor held in a small scoreboard class. Depends on grc_pkg.
`timescale 1ns / 1ps
module tb_top;
  import grc_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      distance;
    logic             wall_side;
    logic [MAP_W-1:0] hit_x;
    logic [MAP_W-1:0] hit_y;
    logic [POS_W-1:0] intersect_x;
    logic [POS_W-1:0] intersect_y;
    logic [15:0]      strip_height;
  } cast_result_t;

  class cast_scoreboard;
    bit                  wall_map [MAP_CELLS];
    longint unsigned     pos_x, pos_y, plane_mag, scr_w, scr_h;
    longint              dir_x, dir_y;
    cast_result_t        pending [$];
    int                  errors;

    function void reset_state();
      foreach (wall_map[i]) wall_map[i] = 0;
      pos_x = 0; pos_y = 0; dir_x = 65536; dir_y = 0;
      plane_mag = 42553; scr_w = 640; scr_h = 480;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_POS_X: pos_x = v[21:0];
        CFG_POS_Y: pos_y = v[21:0];
        CFG_DIR_X: dir_x = longint'($signed(v[18:0]));
        CFG_DIR_Y: dir_y = longint'($signed(v[18:0]));
        CFG_PLANE: plane_mag = v[17:0];
        CFG_SCR_W: scr_w = v[12:0];
        CFG_SCR_H: scr_h = v[12:0];
        default: ;
      endcase
    endfunction

    function longint fshift(longint v);
      if (v >= 0) return v >>> FRAC_BITS;
      return -((-v + 65535) >>> FRAC_BITS);
    endfunction

    function longint ray_part(longint d, longint p, longint scale);
      longint t, r;
      t = fshift(p * longint'(plane_mag));
      r = d + fshift(t * scale);
      if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
      if (r < -64'sh7FFFFFFF) r = -64'sh7FFFFFFF;
      return r;
    endfunction

    function longint unsigned absval(longint r);
      return r < 0 ? -r : r;
    endfunction

    function longint unsigned sat32(longint unsigned v);
      return v > 64'hFFFFFFFF ? 64'hFFFFFFFF : v;
    endfunction

    function longint unsigned delta_of(longint r);
      if (r == 0) return 64'hFFFFFFFF;
      return sat32((64'd1 << 32) / absval(r));
    endfunction

    function longint unsigned first_side(longint unsigned p, longint r,
                                         longint unsigned d);
      longint unsigned fr;
      fr = p & 64'hFFFF;
      return sat32((((r >= 0) ? (64'd65536 - fr) : fr) * d) >> FRAC_BITS);
    endfunction

    function longint unsigned hit_point(longint unsigned p, longint r,
                                        longint unsigned ray_len);
      longint off, q;
      off = longint'((absval(r) * ray_len) >> FRAC_BITS);
      q = r < 0 ? longint'(p) - off : longint'(p) + off;
      if (q < 0) q = 0;
      if (q > (MAP_SIZE << FRAC_BITS) - 1) q = (MAP_SIZE << FRAC_BITS) - 1;
      return q;
    endfunction

    function int clamp_cell(int c);
      if (c < 0) return 0;
      if (c >= MAP_SIZE) return MAP_SIZE - 1;
      return c;
    endfunction

    function void note_request(logic o, logic [5:0] x, logic [5:0] y, logic w,
                               logic [11:0] col);
      cast_result_t e;
      longint unsigned sw, dx, dy, sx, sy, ray_len, lh;
      longint scale, rx, ry;
      int cx, cy;
      bit side, walled;
      e = '0;
      if (o == OP_WRITE) begin
        wall_map[int'(y) * MAP_SIZE + int'(x)] = w;
        e.status = STATUS_WRITE;
        pending.push_back(e);
        return;
      end
      sw = scr_w == 0 ? 1 : scr_w;
      scale = longint'(((64'd2 * col) << FRAC_BITS) / sw) - 65536;
      rx = ray_part(dir_x, -dir_y, scale);
      ry = ray_part(dir_y, dir_x, scale);
      dx = delta_of(rx);
      dy = delta_of(ry);
      sx = first_side(pos_x, rx, dx);
      sy = first_side(pos_y, ry, dy);
      cx = int'(pos_x >> FRAC_BITS);
      cy = int'(pos_y >> FRAC_BITS);
      ray_len = 0;
      side = 0;
      walled = 0;
      for (int n = 0; n < MAX_STEPS && !walled; n++) begin
        if (sx < sy) begin
          cx += rx >= 0 ? 1 : -1;
          ray_len = sx;
          sx = sat32(sx + dx);
          side = 0;
        end else begin
          cy += ry >= 0 ? 1 : -1;
          ray_len = sy;
          sy = sat32(sy + dy);
          side = 1;
        end
        walled = cx < 0 || cy < 0 || cx >= MAP_SIZE || cy >= MAP_SIZE ||
                 wall_map[cy * MAP_SIZE + cx];
      end
      if (ray_len == 0) lh = 65535;
      else begin
        lh = (scr_h << FRAC_BITS) / ray_len;
        if (lh > 65535) lh = 65535;
      end
      e.status = walled ? STATUS_HIT : STATUS_LIMIT;
      e.distance = ray_len[31:0];
      e.wall_side = side;
      e.hit_x = MAP_W'(clamp_cell(cx));
      e.hit_y = MAP_W'(clamp_cell(cy));
      e.intersect_x = POS_W'(hit_point(pos_x, rx, ray_len));
      e.intersect_y = POS_W'(hit_point(pos_y, ry, ray_len));
      e.strip_height = lh[15:0];
      pending.push_back(e);
    endfunction

    function void check_result(cast_result_t got);
      cast_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status); errors++;
      end
      if (got.distance != e.distance) begin
        $display("%0t: distance exp %0h got %0h", $time, e.distance, got.distance);
        errors++;
      end
      if (got.wall_side != e.wall_side) begin
        $display("%0t: wall_side exp %0d got %0d", $time, e.wall_side, got.wall_side);
        errors++;
      end
      if (got.hit_x != e.hit_x) begin
        $display("%0t: hit_x exp %0d got %0d", $time, e.hit_x, got.hit_x); errors++;
      end
      if (got.hit_y != e.hit_y) begin
        $display("%0t: hit_y exp %0d got %0d", $time, e.hit_y, got.hit_y); errors++;
      end
      if (got.intersect_x != e.intersect_x) begin
        $display("%0t: intersect_x exp %0h got %0h", $time, e.intersect_x,
                 got.intersect_x);
        errors++;
      end
      if (got.intersect_y != e.intersect_y) begin
        $display("%0t: intersect_y exp %0h got %0h", $time, e.intersect_y,
                 got.intersect_y);
        errors++;
      end
      if (got.strip_height != e.strip_height) begin
        $display("%0t: strip_height exp %0d got %0d", $time, e.strip_height,
                 got.strip_height);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, op, cell_wall;
  logic [MAP_W-1:0] cell_x, cell_y, hit_x, hit_y;
  logic [COL_W-1:0] column;
  logic out_valid, out_ready, wall_side;
  logic [1:0] status;
  logic [31:0] distance;
  logic [POS_W-1:0] intersect_x, intersect_y;
  logic [15:0] strip_height;

  cast_scoreboard sb;
  int idle_cycles;
  int hold_off;

  grid_ray_caster_dda DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_request(logic o, logic [5:0] x, logic [5:0] y, logic w,
                              logic [11:0] col, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; op <= o; cell_x <= x; cell_y <= y; cell_wall <= w; column <= col;
    do @(posedge clk); while (!in_ready);
    sb.note_request(o, x, y, w, col);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic cast_col(logic [11:0] col);
    send_request(OP_CAST, 6'($urandom), 6'($urandom), 1'($urandom), col, 1);
  endtask

  task automatic set_wall(int x, int y, bit w);
    send_request(OP_WRITE, 6'(x), 6'(y), w, 12'($urandom), 1);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int wait_n;
    out_ready = 0;
    @(negedge rst);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      out_ready <= ($urandom_range(0, 2) == 0) || ($urandom_range(0, 1) == 1);
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result({status, distance, wall_side, hit_x, hit_y, intersect_x,
                         intersect_y, strip_height});
      if (!out_ready || !out_valid) begin
        wait_n = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0 && wait_n > 0) begin
          out_ready <= 0;
          repeat (wait_n) @(posedge clk);
        end
      end
    end
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.reset_state();
    hold_off = 0;
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; op = 0; cell_x = 0; cell_y = 0; cell_wall = 0; column = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default config, empty map, extremes
    cast_col(0); cast_col(320); cast_col(639); cast_col(4095);
    set_wall(63, 63, 1); set_wall(0, 0, 1); set_wall(5, 0, 1); set_wall(0, 0, 0);
    cast_col(320);
    drain();
    write_reg(CFG_POS_X, 22'h3FFFFF); write_reg(CFG_POS_Y, 22'h3FFFFF);
    write_reg(CFG_DIR_X, 19'h20000); write_reg(CFG_DIR_Y, 19'h60000);
    write_reg(CFG_PLANE, 18'h3FFFF); write_reg(CFG_SCR_W, 13'd4096);
    write_reg(CFG_SCR_H, 13'd4096);
    cast_col(0); cast_col(2048); cast_col(4095);
    drain();
    // zero width, zero ray component, zero height, start at a cell centre
    write_reg(CFG_POS_X, 22'h28000); write_reg(CFG_POS_Y, 22'h28000);
    write_reg(CFG_DIR_X, 19'h0); write_reg(CFG_DIR_Y, 19'h10000);
    write_reg(CFG_PLANE, 18'h0); write_reg(CFG_SCR_W, 13'd0);
    write_reg(CFG_SCR_H, 13'd0);
    cast_col(0); cast_col(1);
    drain();
    write_reg(CFG_SCR_H, 13'd1);
    write_reg(CFG_SCR_W, 13'd1);
    drain();
    // long walk: a diagonal ray from the map corner gives many steps
    write_reg(CFG_POS_X, 22'h0); write_reg(CFG_POS_Y, 22'h0);
    write_reg(CFG_DIR_X, 19'h10000); write_reg(CFG_DIR_Y, 19'h10000);
    cast_col(0); cast_col(4095);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_POS_X, 22'($urandom_range(0, 22'h3FFFFF) &
                               ((ph % 2) ? 22'h3FFFFF : 22'h1FFFFF)));
      write_reg(CFG_POS_Y, 22'($urandom_range(0, 22'h3FFFFF)));
      write_reg(CFG_DIR_X, 22'($urandom_range(0, 262144) - 131072));
      write_reg(CFG_DIR_Y, 22'($urandom_range(0, 262144) - 131072));
      write_reg(CFG_PLANE, ph == 3 ? 22'h3FFFF : 22'($urandom_range(0, 100000)));
      write_reg(CFG_SCR_W, ph == 5 ? 22'd1 : 22'($urandom_range(1, 4096)));
      write_reg(CFG_SCR_H, 22'($urandom_range(0, 4096)));
      if (ph == 2) hold_off = 600;
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 2) == 0)
          set_wall($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
        else if ($urandom_range(0, 9) == 0)
          cast_col(12'($urandom));
        else
          cast_col(12'($urandom_range(0, sb.scr_w == 0 ? 0 : sb.scr_w - 1)));
      end
      drain();
    end

    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/grc_pkg.sv
rtl/core/grc_ram.sv
rtl/core/grc_div.sv
rtl/core/grid_ray_caster_dda.sv
rtl/core/grc_checker.sv
tb/tb_top.sv
